// ----- src/linear_diophantine_solver_macros.svh -----
// Assertion macros for the linear Diophantine solver.
// Used by the top level; no other dependencies.
`ifndef LINEAR_DIOPHANTINE_SOLVER_MACROS_SVH
`define LINEAR_DIOPHANTINE_SOLVER_MACROS_SVH
`ifndef SYNTH
// Check that a property holds on every rising clock edge outside reset.
`define LDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds.
`define LDS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LDS_ASSERT(label, clk, rst, prop, msg)
`define LDS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- src/lds_pkg.sv -----
// Shared types and constants of the linear Diophantine solver.
// No dependencies.
`timescale 1ns / 1ps
package lds_pkg;
   localparam int PROD_W = 64;

   localparam logic [1:0] ST_SOLVABLE  = 2'd0;
   localparam logic [1:0] ST_NO_DIV    = 2'd1;
   localparam logic [1:0] ST_BOTH_ZERO = 2'd2;

   typedef struct packed {
      logic        [30:0] divisor_g;
      logic signed [31:0] bezout_x;
      logic signed [31:0] bezout_y;
      logic        [1:0]  status;
      logic signed [63:0] particular_x;
      logic signed [63:0] particular_y;
      logic signed [31:0] step_x;
      logic signed [31:0] step_y;
   } rsp_type;
endpackage

// ----- src/lds_if.sv -----
// Request and response channel interfaces of the solver.
// Depends on lds_pkg.
`timescale 1ns / 1ps
interface lds_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coef_a;
   logic signed [31:0] coef_b;
   logic signed [31:0] rhs_c;
   modport source (output valid, coef_a, coef_b, rhs_c, input ready);
   modport sink (input valid, coef_a, coef_b, rhs_c, output ready);
endinterface

interface lds_rsp_if;
   import lds_pkg::*;
   logic               valid;
   logic               ready;
   logic        [30:0] divisor_g;
   logic signed [31:0] bezout_x;
   logic signed [31:0] bezout_y;
   logic        [1:0]  status;
   logic signed [63:0] particular_x;
   logic signed [63:0] particular_y;
   logic signed [31:0] step_x;
   logic signed [31:0] step_y;
   modport source (output valid, divisor_g, bezout_x, bezout_y, status, particular_x,
                   particular_y, step_x, step_y, input ready);
   modport sink (input valid, divisor_g, bezout_x, bezout_y, status, particular_x,
                 particular_y, step_x, step_y, output ready);
endinterface

// ----- src/lds_alu.sv -----
// Shared adder/subtractor with carry out, used by every divide and multiply step.
// No dependencies.
`timescale 1ns / 1ps
module lds_alu #(
   parameter int UW = 64
) (
   input  logic [UW-1:0] a_i,
   input  logic [UW-1:0] b_i,
   input  logic          sub_i,
   output logic [UW:0]   sum_o
);
   // Add, or subtract in two's complement; the top bit is the carry out
   assign sum_o = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{UW{1'b0}}, sub_i};
endmodule

// ----- src/lds_ctrl.sv -----
// Sequencer and datapath registers of the solver: Euclid loop, divisions, products.
// Depends on lds_pkg and lds_alu.
`timescale 1ns / 1ps
module lds_ctrl #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_i,
   input  logic signed [31:0] coef_a_i,
   input  logic signed [31:0] coef_b_i,
   input  logic signed [31:0] rhs_c_i,
   input  logic               free_i,
   output logic               idle_o,
   output logic               done_o,
   output lds_pkg::rsp_type   result_o
);
   import lds_pkg::*;

   localparam int UW = (WIDTH + 1 > PROD_W) ? WIDTH + 1 : PROD_W;
   localparam int CW = $clog2(WIDTH);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_E_DIV  = 10'b0000000010,
      S_E_MULS = 10'b0000000100,
      S_E_MULT = 10'b0000001000,
      S_C_DIV  = 10'b0000010000,
      S_P_MULX = 10'b0000100000,
      S_P_MULY = 10'b0001000000,
      S_SX_DIV = 10'b0010000000,
      S_SY_DIV = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic              na_ff, na_in, nb_ff, nb_in, nc_ff, nc_in;
   logic [WIDTH-1:0]  ma_ff, ma_in, mb_ff, mb_in, mc_ff, mc_in;
   logic [WIDTH-1:0]  r1_ff, r1_in, g_ff, g_in, dvs_ff, dvs_in;
   logic [WIDTH-1:0]  q_ff, q_in, rem_ff, rem_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [UW-1:0]     s0_ff, s0_in, s1_ff, s1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [UW-1:0]     u_ff, u_in, v_ff, v_in;
   logic [UW-1:0]     acc_ff, acc_in, mcand_ff, mcand_in;
   logic [PROD_W-1:0] mplier_ff, mplier_in;
   logic [1:0]        status_ff, status_in;
   logic [63:0]       px_ff, px_in, py_ff, py_in;
   logic [31:0]       sx_ff, sx_in, sy_ff, sy_in;

   logic [WIDTH-1:0]  raw_a, raw_b, raw_c, mag_a, mag_b, mag_c;
   logic [UW-1:0]     alu_a, alu_b;
   logic              alu_sub;
   logic [UW:0]       alu_sum;
   logic              div_ok, div_last, mul_state, mul_last;
   logic [WIDTH-1:0]  rem_step, q_step;
   logic [UW-1:0]     acc_step;
   logic [PROD_W-1:0] mplier_step, q_wide, qc_wide, qc_signed, qd_wide;

   lds_alu #(.UW(UW)) u_alu (
      .a_i   (alu_a),
      .b_i   (alu_b),
      .sub_i (alu_sub),
      .sum_o (alu_sum)
   );

   // Split the operands into sign and magnitude
   assign raw_a = WIDTH'($unsigned(coef_a_i));
   assign raw_b = WIDTH'($unsigned(coef_b_i));
   assign raw_c = WIDTH'($unsigned(rhs_c_i));
   assign mag_a = raw_a[WIDTH-1] ? -raw_a : raw_a;
   assign mag_b = raw_b[WIDTH-1] ? -raw_b : raw_b;
   assign mag_c = raw_c[WIDTH-1] ? -raw_c : raw_c;

   // Steer the shared unit: restoring divide step or shift-add/subtract multiply step
   assign mul_state = (state_ff == S_E_MULS) || (state_ff == S_E_MULT) ||
                      (state_ff == S_P_MULX) || (state_ff == S_P_MULY);
   assign alu_a   = mul_state ? acc_ff : UW'({rem_ff, q_ff[WIDTH-1]});
   assign alu_b   = mul_state ? mcand_ff : UW'(dvs_ff);
   assign alu_sub = !((state_ff == S_P_MULX) || (state_ff == S_P_MULY));

   // Divide step results
   assign div_ok   = alu_sum[UW];
   assign rem_step = div_ok ? alu_sum[WIDTH-1:0] : {rem_ff[WIDTH-2:0], q_ff[WIDTH-1]};
   assign q_step   = {q_ff[WIDTH-2:0], div_ok};
   assign div_last = (cnt_ff == CW'(WIDTH - 1));

   // Multiply step results
   assign acc_step    = mplier_ff[0] ? alu_sum[UW-1:0] : acc_ff;
   assign mplier_step = mplier_ff >> 1;
   assign mul_last    = (mplier_step == '0);

   // Signed quotients for the particular solution and the steps
   assign q_wide    = PROD_W'(q_step);
   assign qc_wide   = (state_ff == S_C_DIV) ? q_wide : PROD_W'(q_ff);
   assign qc_signed = nc_ff ? -qc_wide : qc_wide;
   assign qd_wide   = -q_wide;

   // Next-state and datapath logic
   always_comb begin
      state_in  = state_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      nc_in     = nc_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      mc_in     = mc_ff;
      r1_in     = r1_ff;
      g_in      = g_ff;
      dvs_in    = dvs_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      s0_in     = s0_ff;
      s1_in     = s1_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      status_in = status_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;

      if (state_ff != S_IDLE && state_ff != S_DONE) begin
         if (mul_state) begin
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_step;
         end else begin
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff + CW'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               na_in     = raw_a[WIDTH-1];
               nb_in     = raw_b[WIDTH-1];
               nc_in     = raw_c[WIDTH-1];
               ma_in     = mag_a;
               mb_in     = mag_b;
               mc_in     = mag_c;
               status_in = ST_SOLVABLE;
               px_in     = '0;
               py_in     = '0;
               sx_in     = '0;
               sy_in     = '0;
               rem_in    = '0;
               cnt_in    = '0;
               if (mag_a == '0 && mag_b == '0) begin
                  status_in = ST_BOTH_ZERO;
                  g_in      = '0;
                  u_in      = '0;
                  v_in      = '0;
                  state_in  = S_DONE;
               end else if (mag_b == '0) begin
                  g_in     = mag_a;
                  u_in     = raw_a[WIDTH-1] ? '1 : UW'(1);
                  v_in     = '0;
                  dvs_in   = mag_a;
                  q_in     = mag_c;
                  state_in = S_C_DIV;
               end else begin
                  r1_in    = mag_b;
                  s0_in    = UW'(1);
                  s1_in    = '0;
                  t0_in    = '0;
                  t1_in    = UW'(1);
                  dvs_in   = mag_b;
                  q_in     = mag_a;
                  state_in = S_E_DIV;
               end
            end
         end
         S_E_DIV: begin
            if (div_last) begin
               if (rem_step == '0) begin
                  // Remainder zero: the divisor is the gcd
                  g_in     = r1_ff;
                  u_in     = na_ff ? -s1_ff : s1_ff;
                  v_in     = nb_ff ? -t1_ff : t1_ff;
                  dvs_in   = r1_ff;
                  q_in     = mc_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_C_DIV;
               end else begin
                  acc_in    = s0_ff;
                  mcand_in  = s1_ff;
                  mplier_in = q_wide;
                  state_in  = S_E_MULS;
               end
            end
         end
         S_E_MULS: begin
            if (mul_last) begin
               s0_in     = s1_ff;
               s1_in     = acc_step;
               acc_in    = t0_ff;
               mcand_in  = t1_ff;
               mplier_in = PROD_W'(q_ff);
               state_in  = S_E_MULT;
            end
         end
         S_E_MULT: begin
            if (mul_last) begin
               // Advance the remainder and coefficient pairs
               t0_in    = t1_ff;
               t1_in    = acc_step;
               r1_in    = rem_ff;
               dvs_in   = rem_ff;
               q_in     = r1_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_E_DIV;
            end
         end
         S_C_DIV: begin
            if (div_last) begin
               if (rem_step != '0) begin
                  status_in = ST_NO_DIV;
                  state_in  = S_DONE;
               end else begin
                  acc_in    = '0;
                  mcand_in  = u_ff;
                  mplier_in = qc_signed;
                  state_in  = S_P_MULX;
               end
            end
         end
         S_P_MULX: begin
            if (mul_last) begin
               px_in     = acc_step[63:0];
               acc_in    = '0;
               mcand_in  = v_ff;
               mplier_in = qc_signed;
               state_in  = S_P_MULY;
            end
         end
         S_P_MULY: begin
            if (mul_last) begin
               py_in    = acc_step[63:0];
               dvs_in   = g_ff;
               q_in     = mb_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_SX_DIV;
            end
         end
         S_SX_DIV: begin
            if (div_last) begin
               sx_in    = nb_ff ? qd_wide[31:0] : q_wide[31:0];
               q_in     = ma_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_SY_DIV;
            end
         end
         S_SY_DIV: begin
            if (div_last) begin
               sy_in    = na_ff ? q_wide[31:0] : qd_wide[31:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (free_i) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      nc_ff     <= nc_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      mc_ff     <= mc_in;
      r1_ff     <= r1_in;
      g_ff      <= g_in;
      dvs_ff    <= dvs_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      status_ff <= status_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
   end

   assign idle_o = (state_ff == S_IDLE);
   assign done_o = (state_ff == S_DONE);

   // Pack the finished result
   assign result_o.divisor_g    = 31'(g_ff);
   assign result_o.bezout_x     = u_ff[31:0];
   assign result_o.bezout_y     = v_ff[31:0];
   assign result_o.status       = status_ff;
   assign result_o.particular_x = px_ff;
   assign result_o.particular_y = py_ff;
   assign result_o.step_x       = sx_ff;
   assign result_o.step_y       = sy_ff;
endmodule

// ----- src/linear_diophantine_solver.sv -----
// Linear Diophantine solver a*x + b*y = c, top level.
// Channels: req_ch carries coef_a, coef_b, rhs_c; rsp_ch returns gcd, Bezout
// coefficients, status, particular solution and general-solution steps.
// A request is taken when valid and ready are both high. Ready is high only
// while the sequencer is idle; one request is worked on at a time.
// Sequence: each Euclid step takes one restoring division plus two
// shift-subtract products whose length is the bit length of the quotient,
// all on one shared adder. After the loop come the division of |c| by g and,
// if g divides |c|, two 64-bit products and two more divisions. Both
// coefficients zero go straight from idle to done.
// The result sits in an output register: a new request is taken while it
// waits; if the receiver still stalls when the next result is done, the
// sequencer holds it and stays busy.
// Reset (synchronous, active high) returns to idle and drops any pending result.
// Depends on lds_pkg, lds_if, lds_ctrl and the macro header.
`timescale 1ns / 1ps
`include "linear_diophantine_solver_macros.svh"
module linear_diophantine_solver #(
   parameter int WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   lds_req_if.sink   req_ch,
   lds_rsp_if.source rsp_ch
);
   import lds_pkg::*;

   logic    idle, done, load;
   logic    valid_ff, valid_in;
   rsp_type result, rsp_ff, rsp_in;

   // Load the output register when it is empty or being drained
   assign load = done && (!valid_ff || rsp_ch.ready);

   lds_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start_i  (req_ch.valid && idle),
      .coef_a_i (req_ch.coef_a),
      .coef_b_i (req_ch.coef_b),
      .rhs_c_i  (req_ch.rhs_c),
      .free_i   (load),
      .idle_o   (idle),
      .done_o   (done),
      .result_o (result)
   );

   assign req_ch.ready = idle;

   // Output register
   assign valid_in = load || (valid_ff && !rsp_ch.ready);
   assign rsp_in   = load ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.divisor_g    = rsp_ff.divisor_g;
   assign rsp_ch.bezout_x     = rsp_ff.bezout_x;
   assign rsp_ch.bezout_y     = rsp_ff.bezout_y;
   assign rsp_ch.status       = rsp_ff.status;
   assign rsp_ch.particular_x = rsp_ff.particular_x;
   assign rsp_ch.particular_y = rsp_ff.particular_y;
   assign rsp_ch.step_x       = rsp_ff.step_x;
   assign rsp_ch.step_y       = rsp_ff.step_y;

   // Checks
   `LDS_ASSERT(a_busy_after_req, clock, reset, (req_ch.valid && req_ch.ready) |=> !req_ch.ready, "ready after accepted request")
   `LDS_ASSERT(a_zero_gcd, clock, reset, (rsp_ch.valid && rsp_ch.status == ST_BOTH_ZERO) |-> (rsp_ch.divisor_g == 31'd0), "nonzero gcd with both coefficients zero")
   `LDS_ASSERT_NEVER(a_unsolved_zero, clock, reset, rsp_ch.valid && rsp_ch.status != ST_SOLVABLE && (rsp_ch.particular_x != 64'd0 || rsp_ch.step_x != 32'd0), "solution fields set on unsolvable result")
endmodule

// ----- verif/lds_tb_if.sv -----
// Testbench-side note: channel interfaces come from the RTL file lds_if.sv.
// This file holds the small shared helper package of the testbench; depends on lds_pkg.
`timescale 1ns / 1ps
package lds_tb_pkg;
   import lds_pkg::*;

   // one request as the testbench sees it
   typedef struct {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] rhs_c;
   } req_type;
endpackage

// ----- verif/linear_diophantine_solver_tb.sv -----
// Testbench of linear_diophantine_solver: drives requests with random gaps, predicts each
// response with an independent extended-Euclid model and compares all fields at once.
// Depends on lds_pkg, lds_tb_pkg, lds_if and the solver RTL.
`timescale 1ns / 1ps
module linear_diophantine_solver_tb;
   import lds_pkg::*;
   import lds_tb_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lds_req_if req_ch ();
   lds_rsp_if rsp_ch ();

   linear_diophantine_solver #(.WIDTH(32)) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Solve a*x + b*y = c on exact magnitudes, the way the block is specified.
   function automatic rsp_type solve_equation(req_type r);
      rsp_type     res;
      logic [63:0] ma, mb, mc, r0, r1, s0, s1, t0, t1, q, r2, s2, t2, g, u, v, cq;
      bit          na, nb, nc;
      na = r.coef_a[31];
      nb = r.coef_b[31];
      nc = r.rhs_c[31];
      ma = na ? -{{32{1'b1}}, r.coef_a} : {32'd0, r.coef_a};
      mb = nb ? -{{32{1'b1}}, r.coef_b} : {32'd0, r.coef_b};
      mc = nc ? -{{32{1'b1}}, r.rhs_c} : {32'd0, r.rhs_c};
      res = '0;
      if (ma == 0 && mb == 0) begin
         res.status = ST_BOTH_ZERO;
         return res;
      end
      if (mb == 0) begin
         g = ma; u = 1; v = 0;
      end else begin
         r0 = ma; r1 = mb; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
         while (r0 % r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            s2 = s0 - q * s1;
            t2 = t0 - q * t1;
            r0 = r1; r1 = r2;
            s0 = s1; s1 = s2;
            t0 = t1; t1 = t2;
         end
         g = r1; u = s1; v = t1;
      end
      if (na) u = -u;
      if (nb) v = -v;
      res.divisor_g = g[30:0];
      res.bezout_x  = u[31:0];
      res.bezout_y  = v[31:0];
      if (mc % g != 0) begin
         res.status = ST_NO_DIV;
      end else begin
         cq = mc / g;
         if (nc) cq = -cq;
         res.status       = ST_SOLVABLE;
         res.particular_x = u * cq;
         res.particular_y = v * cq;
         t2 = mb / g;
         res.step_x = nb ? -t2[31:0] : t2[31:0];
         t2 = ma / g;
         res.step_y = na ? t2[31:0] : -t2[31:0];
      end
      return res;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 7) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Send one request after a random gap; queue its prediction on acceptance.
   // Valid stays high into the next request when there is no gap.
   task automatic send_request(logic signed [31:0] a, logic signed [31:0] b,
                               logic signed [31:0] c);
      req_type r;
      int      gap;
      r.coef_a = a;
      r.coef_b = b;
      r.rhs_c  = c;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.coef_a <= a;
      req_ch.coef_b <= b;
      req_ch.rhs_c  <= c;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsps.push_back(solve_equation(r));
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return $urandom_range(0, 2000) - 1000;
         2: return $signed($urandom()) >>> $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      send_request(0, 0, 0);
      send_request(0, 0, 5);
      send_request(12, 0, 24);
      send_request(-12, 0, 7);
      send_request(0, 9, -18);
      send_request(0, -9, 18);
      send_request(6, 3, 9);
      send_request(-6, 3, 9);
      send_request(240, 46, 4);
      send_request(240, -46, -4);
      send_request(-240, 46, 3);
      send_request(32'h7fffffff, 32'h7ffffffe, 32'h7fffffff);
      send_request(32'h80000001, 32'h7fffffff, 32'h80000001);
      send_request(32'h80000000, 32'h80000000, 32'h80000000);
      send_request(32'h80000000, 6, 32'h7fffffff);
      send_request(32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_request(1836311903, 1134903170, 32'h7fffffff);
      send_request(-1836311903, 1134903170, 32'h80000000);
      send_request(65536, 32'h80000000, 32'h80000000);
      send_request(1, 1, 0);
   endtask

   task automatic test_random();
      logic signed [31:0] a, b, g;
      repeat (350) begin
         a = rand_word();
         b = rand_word();
         // share a common factor now and then, so that the gcd is often above one
         if ($urandom_range(0, 2) == 0) begin
            g = $urandom_range(2, 1000);
            a = (a % 2000000) * g;
            b = (b % 2000000) * g;
         end
         if ($urandom_range(0, 19) == 0) a = 0;
         if ($urandom_range(0, 19) == 0) b = 0;
         send_request(a, b, rand_word());
      end
   endtask

   // Hold ready low for random stretches; check each accepted response.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= (pick_gap() == 0);
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.divisor_g    = rsp_ch.divisor_g;
         got.bezout_x     = rsp_ch.bezout_x;
         got.bezout_y     = rsp_ch.bezout_y;
         got.status       = rsp_ch.status;
         got.particular_x = rsp_ch.particular_x;
         got.particular_y = rsp_ch.particular_y;
         got.step_x       = rsp_ch.step_x;
         got.step_y       = rsp_ch.step_y;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // Watchdog: count cycles with no accepted request or response.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("linear_diophantine_solver_tb: errors");
         $finish;
      end
   end

   initial begin
      int waited;
      req_ch.valid  = 1'b0;
      req_ch.coef_a = '0;
      req_ch.coef_b = '0;
      req_ch.rhs_c  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      req_ch.valid <= 1'b0;
      // drain outstanding responses, then a short settle time
      waited = 0;
      while (expected_rsps.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2000) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("linear_diophantine_solver_tb: clean");
      else
         $display("linear_diophantine_solver_tb: errors");
      $finish;
   end
endmodule
